/* rtl/fsgcc_pkg.sv */
// Shared types, constants and a helper function of the greedy column chooser.
// Used by every module of the block but fsgcc_ram; depends on nothing else.
package fsgcc_pkg;

  localparam int SYM_W      = 2;
  localparam int CNT_W      = 13;
  localparam int FAR_W      = 8;
  localparam int OP_W       = 2;
  localparam int ROW_IDX_W  = 7;
  localparam int RND_W      = 8;
  localparam int ROWS_CFG_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_ROWS = 128;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [FAR_W-1:0] FAR_MAX = {FAR_W{1'b1}};

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 8'd128;
  localparam logic [CNT_W-1:0]      COLS_RESET = 13'd4096;
  localparam logic [CNT_W-1:0]      GOAL_RESET = 13'd3072;

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_DECIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GOAL = 2'd2;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    logic             live;
    logic [CNT_W-1:0] miss_cnt;
    logic [CNT_W-1:0] hit_cnt;
  } row_rec_t;

  localparam row_rec_t REC_RESET = '{live: 1'b1, miss_cnt: '0, hit_cnt: '0};

  typedef struct packed {
    logic en;
    sym_t sym;
    logic live;
    logic near;
  } row_view_t;

  // Residue of an 8-bit value modulo three; powers of four are one modulo three.
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
    s3 = 3'(s2[2]) + 3'(s2[1:0]);
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

endpackage

/* rtl/fsgcc_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing else.
module fsgcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fsgcc_tally.sv */
// Per-symbol score accumulators and the tie-breaking symbol pick.
// Depends on fsgcc_pkg.
module fsgcc_tally #(
  parameter int MAX_ROWS = fsgcc_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          clear,
  input  fsgcc_pkg::row_view_t          row,
  input  logic                          use_dist,
  input  logic [fsgcc_pkg::RND_W-1:0]   tie_random,
  output fsgcc_pkg::sym_t               chosen,
  output logic                          by_dist
);

  localparam int SW = $clog2(MAX_ROWS + 1);

  logic [3:0][SW-1:0] dist_cnt;
  logic [3:0][SW-1:0] rare_cnt;
  logic [2:0]         dist_pick;
  logic [2:0]         rare_pick;

  // Returns {extreme is nonzero, picked symbol}.
  function automatic logic [2:0] pick(input logic [3:0][SW-1:0] score, input logic want_max,
                                      input logic [fsgcc_pkg::RND_W-1:0] rnd);
    logic [SW-1:0] best_v;
    logic [2:0]    n;
    logic [1:0]    idx;
    logic [1:0]    seen;
    logic [1:0]    res;
    best_v = score[0];
    for (int k = 1; k < 4; k++) begin
      if (want_max ? (score[k] > best_v) : (score[k] < best_v)) begin
        best_v = score[k];
      end
    end
    n = '0;
    for (int k = 0; k < 4; k++) begin
      if (score[k] == best_v) begin
        n = n + 3'd1;
      end
    end
    case (n)
      3'd1: idx = 2'd0;
      3'd2: idx = {1'b0, rnd[0]};
      3'd3: idx = fsgcc_pkg::mod3(rnd);
      default: idx = rnd[1:0];
    endcase
    seen = '0;
    res  = '0;
    for (int k = 0; k < 4; k++) begin
      if (score[k] == best_v) begin
        if (seen == idx) begin
          res = 2'(k);
        end
        seen = seen + 2'd1;
      end
    end
    return {best_v != '0, res};
  endfunction

  always_ff @(posedge clk) begin
    if (clear) begin
      dist_cnt <= '0;
      rare_cnt <= '0;
    end else if (row.en && row.live) begin
      for (int k = 0; k < 4; k++) begin
        if (row.near && row.sym != 2'(k)) begin
          dist_cnt[k] <= dist_cnt[k] + SW'(1);
        end
      end
      rare_cnt[row.sym] <= rare_cnt[row.sym] + SW'(1);
    end
  end

  assign dist_pick = pick(dist_cnt, 1'b1, tie_random);
  assign rare_pick = pick(rare_cnt, 1'b0, tie_random);
  assign by_dist   = use_dist && dist_pick[2];
  assign chosen    = by_dist ? dist_pick[1:0] : rare_pick[1:0];

endmodule

/* rtl/fsgcc_row_upd.sv */
// Read-modify-write logic of one row record after a column choice.
// Depends on fsgcc_pkg.
module fsgcc_row_upd (
  input  fsgcc_pkg::row_rec_t                 rec,
  input  fsgcc_pkg::sym_t                     sym,
  input  fsgcc_pkg::sym_t                     chosen,
  input  logic [fsgcc_pkg::CNT_W-1:0]         goal,
  input  logic signed [fsgcc_pkg::CNT_W+1:0]  match_limit,
  output fsgcc_pkg::row_rec_t                 rec_next,
  output logic                                to_far
);

  logic [fsgcc_pkg::CNT_W-1:0] hit_inc;
  logic [fsgcc_pkg::CNT_W-1:0] miss_inc;

  assign hit_inc  = (rec.hit_cnt < fsgcc_pkg::CNT_MAX) ? rec.hit_cnt + 1'b1 : rec.hit_cnt;
  assign miss_inc = (rec.miss_cnt < fsgcc_pkg::CNT_MAX) ? rec.miss_cnt + 1'b1 : rec.miss_cnt;

  always_comb begin
    rec_next = rec;
    to_far   = 1'b0;
    if (rec.live) begin
      if (sym == chosen) begin
        rec_next.hit_cnt = hit_inc;
        if ($signed({2'b00, hit_inc}) == match_limit) begin
          rec_next.live = 1'b0;
        end
      end else begin
        rec_next.miss_cnt = miss_inc;
        if (miss_inc == goal) begin
          rec_next.live = 1'b0;
          to_far        = 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/far_string_greedy_column_chooser_unit.sv */
// Top level of the greedy column chooser: sequencer, configuration, row memories.
// Depends on fsgcc_pkg, fsgcc_ram, fsgcc_tally and fsgcc_row_upd.
//
// The row symbols and the per-row counter records sit in two single-read-port
// memories, and a decide walks all R rows twice through them, where R is rows_in_use
// capped at MAX_ROWS, one row per cycle, first to score the four symbols and then to
// write back the updated records. Per-row valid bits make a start beat clear the
// records at once, so there is no clearing pass. A finished result waits in an output
// register while the next input beat is accepted.
module far_string_greedy_column_chooser_unit #(
  parameter int MAX_ROWS = fsgcc_pkg::DEF_MAX_ROWS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fsgcc_pkg::OP_W-1:0]           op,
  input  logic [fsgcc_pkg::ROW_IDX_W-1:0]      row_index,
  input  logic [fsgcc_pkg::SYM_W-1:0]          row_symbol,
  input  logic [fsgcc_pkg::RND_W-1:0]          tie_random,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fsgcc_pkg::SYM_W-1:0]          chosen_symbol,
  output logic [fsgcc_pkg::FAR_W-1:0]          far_rows,
  output logic                                 by_distance_rule,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fsgcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsgcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int ROW_CW = $clog2(MAX_ROWS + 1);
  localparam int REC_W  = $bits(fsgcc_pkg::row_rec_t);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCORE  = 5'b00010,
    S_PICK   = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                                 state;
  logic [fsgcc_pkg::ROWS_CFG_W-1:0]       rows_in_use;
  logic [fsgcc_pkg::CNT_W-1:0]            column_count;
  logic [fsgcc_pkg::CNT_W-1:0]            distance_goal;
  logic [ROW_CW-1:0]                      rows_eff;
  logic [ROW_CW-1:0]                      rd_cnt;
  logic                                   rd_pend;
  logic [RAW-1:0]                         rd_addr;
  logic                                   rd_vld;
  logic [RAW-1:0]                         raddr;
  logic                                   issue;
  logic [MAX_ROWS-1:0]                    row_vld;
  logic [fsgcc_pkg::FAR_W-1:0]            far_total;
  logic [fsgcc_pkg::CNT_W-1:0]            cols_done;
  logic                                   use_dist;
  logic [fsgcc_pkg::RND_W-1:0]            rnd_q;
  fsgcc_pkg::sym_t                        chosen;
  logic                                   by_dist;
  fsgcc_pkg::sym_t                        tally_sym;
  logic                                   tally_by_dist;
  logic                                   in_acc;
  logic                                   load_we;
  logic                                   decide_go;
  fsgcc_pkg::sym_t                        sym_q;
  logic [REC_W-1:0]                       rec_q;
  fsgcc_pkg::row_rec_t                    rec_cur;
  fsgcc_pkg::row_rec_t                    rec_next;
  logic                                   to_far;
  logic                                   rec_we;
  fsgcc_pkg::row_view_t                   view;
  logic signed [fsgcc_pkg::CNT_W+1:0]     match_limit;
  logic                                   out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign load_we   = in_acc && (op == fsgcc_pkg::OP_LOAD) && (32'(row_index) < MAX_ROWS);
  assign decide_go = in_acc && (op == fsgcc_pkg::OP_DECIDE);

  assign rows_eff = (32'(rows_in_use) > MAX_ROWS) ? ROW_CW'(MAX_ROWS) : ROW_CW'(rows_in_use);
  assign raddr    = rd_cnt[RAW-1:0];
  assign issue    = ((state == S_SCORE) || (state == S_UPDATE)) && (rd_cnt < rows_eff);

  assign match_limit = $signed({2'b00, column_count}) - $signed({2'b00, distance_goal})
                       + $signed(15'sd1);

  assign rec_cur = rd_vld ? fsgcc_pkg::row_rec_t'(rec_q) : fsgcc_pkg::REC_RESET;
  assign rec_we  = (state == S_UPDATE) && rd_pend;

  assign view.en   = (state == S_SCORE) && rd_pend;
  assign view.sym  = sym_q;
  assign view.live = rec_cur.live;
  assign view.near = ({1'b0, rec_cur.miss_cnt} + 1'b1) >= {1'b0, distance_goal};

  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  fsgcc_ram #(
    .WIDTH(fsgcc_pkg::SYM_W),
    .DEPTH(MAX_ROWS)
  ) u_sym_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(RAW'(row_index)),
    .wdata(row_symbol),
    .raddr(raddr),
    .rdata(sym_q)
  );

  fsgcc_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_ROWS)
  ) u_rec_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rd_addr),
    .wdata(rec_next),
    .raddr(raddr),
    .rdata(rec_q)
  );

  fsgcc_tally #(
    .MAX_ROWS(MAX_ROWS)
  ) u_tally (
    .clk       (clk),
    .clear     (decide_go),
    .row       (view),
    .use_dist  (use_dist),
    .tie_random(rnd_q),
    .chosen    (tally_sym),
    .by_dist   (tally_by_dist)
  );

  fsgcc_row_upd u_row_upd (
    .rec        (rec_cur),
    .sym        (sym_q),
    .chosen     (chosen),
    .goal       (distance_goal),
    .match_limit(match_limit),
    .rec_next   (rec_next),
    .to_far     (to_far)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= fsgcc_pkg::ROWS_RESET;
      column_count  <= fsgcc_pkg::COLS_RESET;
      distance_goal <= fsgcc_pkg::GOAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fsgcc_pkg::REG_ROWS_IN_USE:   rows_in_use   <= cfg_data[fsgcc_pkg::ROWS_CFG_W-1:0];
        fsgcc_pkg::REG_COLUMN_COUNT:  column_count  <= cfg_data;
        fsgcc_pkg::REG_DISTANCE_GOAL: distance_goal <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_cnt    <= '0;
      rd_pend   <= 1'b0;
      row_vld   <= '0;
      far_total <= '0;
      cols_done <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && op == fsgcc_pkg::OP_START) begin
            row_vld   <= '0;
            far_total <= '0;
            cols_done <= '0;
          end
          if (decide_go) begin
            rd_cnt <= '0;
            state  <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (!issue && !rd_pend) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          rd_cnt <= '0;
          state  <= S_UPDATE;
        end
        S_UPDATE: begin
          if (rd_pend) begin
            row_vld[rd_addr] <= 1'b1;
            if (to_far && far_total < fsgcc_pkg::FAR_MAX) begin
              far_total <= far_total + 1'b1;
            end
          end
          if (!issue && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            if (cols_done < fsgcc_pkg::CNT_MAX) begin
              cols_done <= cols_done + 1'b1;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr <= raddr;
      rd_vld  <= row_vld[raddr];
    end
    if (decide_go) begin
      use_dist <= (cols_done >= distance_goal);
      rnd_q    <= tie_random;
    end
    if (state == S_PICK) begin
      chosen  <= tally_sym;
      by_dist <= tally_by_dist;
    end
    if (out_load) begin
      chosen_symbol    <= chosen;
      far_rows         <= far_total;
      by_distance_rule <= by_dist;
    end
  end

  a_pick_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> !rd_pend)
    else $error("Score pass left a read in flight when the pick began.");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCORE || state == S_UPDATE) |-> rd_cnt <= rows_eff)
    else $error("Row walk ran past the rows in use.");

  a_update_complete: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && $past(state) == S_UPDATE) |-> rd_cnt == rows_eff)
    else $error("Update pass ended before every row was written back.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("A result beat appeared without a finished decide.");

endmodule

/* dv/fsgcc_column_checker.sv */
`timescale 1ns / 1ps
// Checker for the greedy column chooser. It watches the input, configuration and
// result channels, predicts every column pick and compares it. Depends on fsgcc_pkg.
module fsgcc_column_checker
  import fsgcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [ROW_IDX_W-1:0]  row_index,
  input  logic [SYM_W-1:0]      row_symbol,
  input  logic [RND_W-1:0]      tie_random,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SYM_W-1:0]      chosen_symbol,
  input  logic [FAR_W-1:0]      far_rows,
  input  logic                  by_distance_rule,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int ROWS = DEF_MAX_ROWS;

  typedef struct packed {
    sym_t             sym;
    logic [FAR_W-1:0] far;
    logic             by_dist;
  } column_pick_t;

  logic [ROWS_CFG_W-1:0] rows_cfg;
  logic [CNT_W-1:0]      cols_cfg;
  logic [CNT_W-1:0]      goal_cfg;
  sym_t                  sym_mem  [ROWS];
  logic [CNT_W-1:0]      miss_cnt [ROWS];
  logic [CNT_W-1:0]      hit_cnt  [ROWS];
  logic                  live     [ROWS];
  logic [FAR_W-1:0]      far_total;
  logic [CNT_W-1:0]      cols_done;
  column_pick_t          picks_due [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_rows();
    for (int i = 0; i < ROWS; i++) begin
      miss_cnt[i] = '0;
      hit_cnt[i]  = '0;
      live[i]     = 1'b1;
    end
    far_total = '0;
    cols_done = '0;
  endtask

  function automatic int unsigned tied_symbol(input int unsigned score [4],
                                              input bit want_max,
                                              input logic [RND_W-1:0] rnd,
                                              output int unsigned ext);
    int unsigned best;
    int unsigned n;
    int unsigned list [4];
    best = 0;
    n = 0;
    for (int k = 1; k < 4; k++) begin
      if (want_max ? (score[k] > score[best]) : (score[k] < score[best])) begin
        best = k;
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (score[k] == score[best]) begin
        list[n] = k;
        n++;
      end
    end
    ext = score[best];
    return list[rnd % n];
  endfunction

  task automatic decide_column(input logic [RND_W-1:0] rnd);
    int unsigned  rows;
    int unsigned  score [4];
    int unsigned  ext;
    int unsigned  pick;
    int unsigned  chosen;
    bit           by_dist;
    int           match_limit;
    column_pick_t pick_rec;
    rows = (rows_cfg > ROWS) ? ROWS : rows_cfg;
    match_limit = int'(cols_cfg) - int'(goal_cfg) + 1;
    chosen = 0;
    by_dist = 1'b0;
    if (cols_done >= goal_cfg) begin
      for (int k = 0; k < 4; k++) begin
        score[k] = 0;
        for (int i = 0; i < rows; i++) begin
          if (live[i] && sym_mem[i] != k && miss_cnt[i] + 1 >= goal_cfg) begin
            score[k]++;
          end
        end
      end
      pick = tied_symbol(score, 1'b1, rnd, ext);
      if (ext > 0) begin
        chosen = pick;
        by_dist = 1'b1;
      end
    end
    if (!by_dist) begin
      for (int k = 0; k < 4; k++) begin
        score[k] = 0;
      end
      for (int i = 0; i < rows; i++) begin
        if (live[i]) begin
          score[sym_mem[i]]++;
        end
      end
      chosen = tied_symbol(score, 1'b0, rnd, ext);
    end
    for (int i = 0; i < rows; i++) begin
      if (live[i]) begin
        if (sym_mem[i] == chosen) begin
          if (hit_cnt[i] != CNT_MAX) begin
            hit_cnt[i]++;
          end
          if (int'(hit_cnt[i]) == match_limit) begin
            live[i] = 1'b0;
          end
        end else begin
          if (miss_cnt[i] != CNT_MAX) begin
            miss_cnt[i]++;
          end
          if (miss_cnt[i] == goal_cfg) begin
            live[i] = 1'b0;
            if (far_total != FAR_MAX) begin
              far_total++;
            end
          end
        end
      end
    end
    if (cols_done != CNT_MAX) begin
      cols_done++;
    end
    pick_rec.sym     = sym_t'(chosen);
    pick_rec.far     = far_total;
    pick_rec.by_dist = by_dist;
    picks_due = {picks_due, pick_rec};
  endtask

  always @(posedge clk) begin : watch
    column_pick_t want;
    if (rst) begin
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      goal_cfg = GOAL_RESET;
      for (int i = 0; i < ROWS; i++) begin
        sym_mem[i] = '0;
      end
      clear_rows();
      picks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_IN_USE:   rows_cfg = cfg_data[ROWS_CFG_W-1:0];
          REG_COLUMN_COUNT:  cols_cfg = cfg_data[CNT_W-1:0];
          REG_DISTANCE_GOAL: goal_cfg = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (picks_due.size() == 0) begin
          report_mismatch("result beat with no decide outstanding");
        end else begin
          want = picks_due.pop_front();
          if (chosen_symbol !== want.sym) begin
            report_mismatch($sformatf("chosen_symbol got %0d expected %0d",
                                      chosen_symbol, want.sym));
          end
          if (far_rows !== want.far) begin
            report_mismatch($sformatf("far_rows got %0d expected %0d",
                                      far_rows, want.far));
          end
          if (by_distance_rule !== want.by_dist) begin
            report_mismatch($sformatf("by_distance_rule got %0d expected %0d",
                                      by_distance_rule, want.by_dist));
          end
        end
      end
      if (in_valid && in_ready) begin
        case (op)
          OP_START:  clear_rows();
          OP_LOAD:   sym_mem[row_index] = row_symbol;
          OP_DECIDE: decide_column(tie_random);
          default: ;
        endcase
      end
    end
    pending = picks_due.size();
  end

endmodule

/* dv/far_string_greedy_column_chooser_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the greedy column chooser testbench: clock, reset, stimulus and verdict.
// Depends on fsgcc_pkg, the block and fsgcc_column_checker.
module far_string_greedy_column_chooser_unit_tb;
  import fsgcc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ROWS = DEF_MAX_ROWS;
  localparam int SETTLE_CYCLES = 2 * ROWS + 16;
  localparam int PHASE_ITEMS = 150;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       op;
  logic [ROW_IDX_W-1:0]  row_index;
  logic [SYM_W-1:0]      row_symbol;
  logic [RND_W-1:0]      tie_random;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SYM_W-1:0]      chosen_symbol;
  logic [FAR_W-1:0]      far_rows;
  logic                  by_distance_rule;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int in_idle_pct = 9;
  int out_idle_pct = 66;
  int items_sent = 0;
  int rows_now = ROWS;
  bit row_loaded [ROWS];

  far_string_greedy_column_chooser_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row_index(row_index), .row_symbol(row_symbol), .tie_random(tie_random),
    .out_valid(out_valid), .out_ready(out_ready),
    .chosen_symbol(chosen_symbol), .far_rows(far_rows), .by_distance_rule(by_distance_rule),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fsgcc_column_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row_index(row_index), .row_symbol(row_symbol), .tie_random(tie_random),
    .out_valid(out_valid), .out_ready(out_ready),
    .chosen_symbol(chosen_symbol), .far_rows(far_rows), .by_distance_rule(by_distance_rule),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with valid still high so that a following beat can go out back to back.
  task automatic send_beat(input logic [OP_W-1:0] b_op, input logic [ROW_IDX_W-1:0] b_row,
                           input logic [SYM_W-1:0] b_sym, input logic [RND_W-1:0] b_rnd);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= b_op;
    row_index  <= b_row;
    row_symbol <= b_sym;
    tie_random <= b_rnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_load(input int row, input int sym);
    row_loaded[row] = 1'b1;
    send_beat(OP_LOAD, ROW_IDX_W'(row), SYM_W'(sym), RND_W'($urandom));
  endtask

  task automatic send_decide(input int rnd);
    send_beat(OP_DECIDE, ROW_IDX_W'($urandom), SYM_W'($urandom), RND_W'(rnd));
  endtask

  task automatic send_start();
    send_beat(OP_START, ROW_IDX_W'($urandom), SYM_W'($urandom), RND_W'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input int rows, input int cols, input int goal);
    quiesce();
    write_reg(REG_ROWS_IN_USE, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    write_reg(REG_DISTANCE_GOAL, goal);
    cfg_valid <= 1'b0;
    rows_now = (rows > ROWS) ? ROWS : rows;
  endtask

  function automatic bit rows_defined();
    for (int i = 0; i < rows_now; i++) begin
      if (!row_loaded[i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic load_column(input int upto);
    int mode;
    int base;
    mode = $urandom_range(3);
    base = $urandom_range(3);
    for (int r = 0; r < upto; r++) begin
      case (mode)
        0: send_load(r, base);
        1: send_load(r, (base + $urandom_range(1)) % 4);
        default: send_load(r, $urandom_range(3));
      endcase
    end
  endtask

  task automatic run_random_setting();
    int pick;
    int rows;
    int cols;
    int goal;
    int ncols;
    int small_cols;
    pick = $urandom_range(99);
    if (pick < 80) rows = $urandom_range(1, 10);
    else if (pick < 86) rows = 128;
    else if (pick < 92) rows = 0;
    else rows = $urandom_range(129, 255) | ($urandom_range(31) << 8);
    pick = $urandom_range(99);
    if (pick < 85) cols = $urandom_range(1, 10);
    else if (pick < 91) cols = 4096;
    else if (pick < 96) cols = 8191;
    else cols = 0;
    small_cols = (cols > 10 || cols == 0) ? 10 : cols;
    pick = $urandom_range(99);
    if (pick < 80) goal = $urandom_range(0, small_cols + 2);
    else if (pick < 86) goal = 0;
    else if (pick < 91) goal = 4096;
    else if (pick < 95) goal = 8191;
    else goal = cols;
    configure(rows, cols, goal);
    repeat ($urandom_range(1, 3)) begin
      send_start();
      ncols = (rows_now > 16) ? $urandom_range(1, 2) : small_cols + $urandom_range(0, 2);
      for (int c = 0; c < ncols; c++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          send_beat(OP_UNUSED, ROW_IDX_W'($urandom), SYM_W'($urandom), RND_W'($urandom));
          load_column(rows_now);
        end else if (pick < 7) begin
          send_load($urandom_range(ROWS - 1), $urandom_range(3));
          load_column(rows_now);
        end else if (pick < 9) begin
          send_start();
          load_column(rows_now);
        end else if (pick < 13 && rows_defined()) begin
          load_column($urandom_range(rows_now));
        end else begin
          load_column(rows_now);
        end
        send_decide($urandom_range(255));
      end
    end
  endtask

  initial begin
    int phase_base;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= OP_START;
    row_index  <= '0;
    row_symbol <= '0;
    tie_random <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_ROWS_IN_USE;
    cfg_data   <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Decides under the reset configuration, all rows loaded first.
    for (int r = 0; r < ROWS; r++) begin
      send_load(r, $urandom_range(3));
    end
    send_decide(255);
    send_decide(0);

    configure(3, 4, 2);
    send_start();
    send_load(0, 0);
    send_load(1, 1);
    send_load(2, 1);
    send_decide(255);
    send_decide(0);
    send_decide(1);
    send_decide(2);
    send_beat(OP_UNUSED, 7'h7f, 2'd3, 8'hff);
    send_start();
    send_load(127, 3);
    send_decide(3);
    configure(0, 4096, 0);
    send_decide(7);
    send_decide(0);
    configure(200, 2, 5);
    send_start();
    send_decide(170);
    send_decide(85);
    send_decide(254);
    configure(1, 1, 1);
    send_start();
    send_load(0, 2);
    send_decide(9);
    send_decide(9);

    for (int mode = 0; mode < 3; mode++) begin
      in_idle_pct  = (mode == 0) ? 9 : (mode == 1) ? 66 : 0;
      out_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 9 : 0;
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) begin
        run_random_setting();
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
